[sv/qgdt_pkg.sv]
// Shared types and constants for the quality gated detection table.
package qgdt_pkg;
  localparam int Entries = 32;
  localparam int IdxW = $clog2(Entries);
  localparam int CntW = $clog2(Entries + 1);
  localparam int CfgIdxW = 3;

  localparam logic [2:0] KindQueued = 3'd0;
  localparam logic [2:0] KindSkipped = 3'd1;
  localparam logic [2:0] KindFull = 3'd2;
  localparam logic [2:0] KindSent = 3'd3;
  localparam logic [2:0] KindTickDone = 3'd4;
  localparam logic [2:0] KindDisabled = 3'd5;

  localparam logic [CfgIdxW-1:0] RegEnabled = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSendDelay = 3'd1;
  localparam logic [CfgIdxW-1:0] RegThreshold = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCleanup = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSentTtl = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPendTtl = 3'd5;

  typedef struct packed {
    logic       cmd;
    logic [7:0] src_id;
    logic [63:0] obj_id;
    logic [15:0] quality;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_source_id;
    logic [63:0] out_object_id;
    logic [15:0] out_quality;
    logic       resend;
    logic [7:0] sent_cnt;
    logic [5:0] rm_sent;
    logic [5:0] rm_pend;
    logic [5:0] sent_in_tick;
    logic       is_last;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        data;
  } cfg_item_t;

  typedef enum logic [2:0] {
    StIdle, StSearch, StDetDone, StSweep, StSend, StEmit, StTickDone
  } state_e;

  typedef struct packed {
    logic load;
    logic scan_clear;
    logic scan_next;
    logic det_apply;
    logic sweep_apply;
    logic send_apply;
    logic out_det;
    logic out_sent;
    logic out_done;
    logic out_disabled;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic enabled;
    logic scan_last;
    logic cleanup_due;
    logic send_hit;
    logic out_busy;
  } status_t;
endpackage

[sv/qgdt_if.sv]
// Valid/ready channel interface carrying one payload.
interface qgdt_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/qgdt_ctrl.sv]
// Controller state machine for the detection table.
module qgdt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qgdt_pkg::status_t st_i,
  output qgdt_pkg::cmd_t    cmd_o
);
  import qgdt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StSearch;
        end
      end
      StSearch: begin
        if (!st_i.enabled) begin
          if (!st_i.out_busy) begin
            state_d = StIdle;
          end
        end else if (st_i.is_tick) begin
          state_d = st_i.cleanup_due ? StSweep : StSend;
        end else if (st_i.scan_last) begin
          state_d = StDetDone;
        end
      end
      StDetDone: begin
        if (!st_i.out_busy) begin
          state_d = StIdle;
        end
      end
      StSweep: begin
        if (st_i.scan_last) begin
          state_d = StSend;
        end
      end
      StSend: begin
        if (st_i.send_hit) begin
          state_d = StEmit;
        end else if (st_i.scan_last) begin
          state_d = StTickDone;
        end
      end
      StEmit: begin
        if (!st_i.out_busy) begin
          state_d = st_i.scan_last ? StTickDone : StSend;
        end
      end
      StTickDone: begin
        if (!st_i.out_busy) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        cmd_o.scan_clear = 1'b1;
      end
      StSearch: begin
        if (!st_i.enabled) begin
          cmd_o.out_disabled = !st_i.out_busy;
        end else if (st_i.is_tick) begin
          cmd_o.scan_clear = 1'b1;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      StDetDone: begin
        if (!st_i.out_busy) begin
          cmd_o.det_apply = 1'b1;
          cmd_o.out_det = 1'b1;
        end
      end
      StSweep: begin
        cmd_o.sweep_apply = 1'b1;
        cmd_o.scan_next = 1'b1;
        cmd_o.scan_clear = st_i.scan_last;
      end
      StSend: begin
        if (!st_i.send_hit) begin
          cmd_o.scan_next = 1'b1;
        end
      end
      StEmit: begin
        if (!st_i.out_busy) begin
          cmd_o.send_apply = 1'b1;
          cmd_o.out_sent = 1'b1;
          cmd_o.scan_next = 1'b1;
        end
      end
      StTickDone: begin
        cmd_o.out_done = !st_i.out_busy;
      end
      default: cmd_o = '0;
    endcase
  end
endmodule

[sv/qgdt_dpath.sv]
// Datapath: configuration, entry table, scan pointer and result register.
module qgdt_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qgdt_pkg::in_item_t   in_data_i,
  input  logic                 cfg_we_i,
  input  qgdt_pkg::cfg_item_t  cfg_data_i,
  input  qgdt_pkg::cmd_t       cmd_i,
  output qgdt_pkg::status_t    st_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output qgdt_pkg::out_item_t  out_data_o
);
  import qgdt_pkg::*;

  logic        enabled_q;
  logic [31:0] send_delay_q, cleanup_q, sent_ttl_q, pend_ttl_q, last_cleanup_q;
  logic [15:0] thresh_q;

  logic [7:0]  key_src_q [Entries];
  logic [63:0] key_obj_q [Entries];
  logic [15:0] pend_q_q [Entries];
  logic [31:0] pend_t_q [Entries];
  logic        pend_rs_q [Entries];
  logic [15:0] sent_qa_q [Entries];
  logic [31:0] sent_ls_q [Entries];
  logic [7:0]  sent_n_q [Entries];
  logic [Entries-1:0] pend_v_q, sent_v_q;

  in_item_t    item_q;
  logic [IdxW-1:0] ptr_q;
  logic [IdxW-1:0] idx;
  logic        hit_q, free_found_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  logic [CntW-1:0] rms_q, rmp_q, sit_q;
  logic        out_v_q;
  out_item_t   out_q, out_d;
  logic        out_set;

  logic        occ, key_eq, cur_hit;
  logic [31:0] age_pend, age_sent;
  logic        had_sent, ok;
  logic [16:0] gain;
  logic [7:0]  new_cnt;

  assign idx = ptr_q;
  assign occ = pend_v_q[idx] || sent_v_q[idx];
  assign key_eq = key_src_q[idx] == item_q.src_id && key_obj_q[idx] == item_q.obj_id;
  assign cur_hit = occ && key_eq;
  assign age_pend = item_q.now_ms - pend_t_q[idx];
  assign age_sent = item_q.now_ms - sent_ls_q[idx];

  assign had_sent = hit_q && sent_v_q[hit_idx_q];
  assign gain = {1'b0, item_q.quality} - {1'b0, sent_qa_q[hit_idx_q]};
  always_comb begin
    ok = 1'b1;
    if (had_sent && (gain[16] || gain[15:0] < thresh_q)) begin
      ok = 1'b0;
    end
    if (ok && hit_q && pend_v_q[hit_idx_q] && item_q.quality <= pend_q_q[hit_idx_q]) begin
      ok = 1'b0;
    end
  end
  assign new_cnt = !sent_v_q[idx] ? 8'd1 :
                   (sent_n_q[idx] == 8'hFF ? 8'hFF : sent_n_q[idx] + 8'd1);

  assign st_o.is_tick = item_q.cmd;
  assign st_o.enabled = enabled_q;
  assign st_o.scan_last = ptr_q == IdxW'(Entries - 1);
  assign st_o.cleanup_due = (item_q.now_ms - last_cleanup_q) >= cleanup_q;
  assign st_o.send_hit = pend_v_q[idx] && age_pend >= send_delay_q;
  assign st_o.out_busy = out_v_q && !out_ready_i;

  assign out_set = cmd_i.out_det || cmd_i.out_sent || cmd_i.out_done || cmd_i.out_disabled;

  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      send_delay_q <= 32'd1000;
      thresh_q <= 16'd6554;
      cleanup_q <= 32'd10000;
      sent_ttl_q <= 32'd60000;
      pend_ttl_q <= 32'd30000;
    end else if (cfg_we_i) begin
      case (cfg_data_i.index)
        RegEnabled: enabled_q <= cfg_data_i.data[0];
        RegSendDelay: send_delay_q <= cfg_data_i.data;
        RegThreshold: thresh_q <= cfg_data_i.data[15:0];
        RegCleanup: cleanup_q <= cfg_data_i.data;
        RegSentTtl: sent_ttl_q <= cfg_data_i.data;
        RegPendTtl: pend_ttl_q <= cfg_data_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= '0;
      sent_v_q <= '0;
      last_cleanup_q <= '0;
      ptr_q <= '0;
      out_v_q <= 1'b0;
      hit_q <= 1'b0;
      free_found_q <= 1'b0;
      hit_idx_q <= '0;
      free_idx_q <= '0;
      rms_q <= '0;
      rmp_q <= '0;
      sit_q <= '0;
    end else begin
      if (out_set) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (cmd_i.load) begin
        hit_q <= 1'b0;
        free_found_q <= 1'b0;
        rms_q <= '0;
        rmp_q <= '0;
        sit_q <= '0;
      end
      if (cmd_i.scan_next && !item_q.cmd) begin
        if (cur_hit && !hit_q) begin
          hit_q <= 1'b1;
          hit_idx_q <= idx;
        end
        if (!occ && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q <= idx;
        end
      end
      if (cmd_i.scan_clear) begin
        ptr_q <= '0;
      end else if (cmd_i.scan_next && !st_o.scan_last) begin
        ptr_q <= ptr_q + IdxW'(1);
      end
      if (cmd_i.sweep_apply) begin
        if (sent_v_q[idx] && age_sent > sent_ttl_q) begin
          sent_v_q[idx] <= 1'b0;
          rms_q <= rms_q + CntW'(1);
        end
        if (pend_v_q[idx] && age_pend > pend_ttl_q) begin
          pend_v_q[idx] <= 1'b0;
          rmp_q <= rmp_q + CntW'(1);
        end
        last_cleanup_q <= item_q.now_ms;
      end
      if (cmd_i.send_apply) begin
        pend_v_q[idx] <= 1'b0;
        sent_v_q[idx] <= 1'b1;
        sit_q <= sit_q + CntW'(1);
      end
      if (cmd_i.det_apply && ok && (hit_q || free_found_q)) begin
        if (hit_q) begin
          pend_v_q[hit_idx_q] <= 1'b1;
        end else begin
          pend_v_q[free_idx_q] <= 1'b1;
          sent_v_q[free_idx_q] <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    out_d = out_q;
    if (cmd_i.out_disabled) begin
      out_d = '0;
      out_d.kind = KindDisabled;
      out_d.is_last = 1'b1;
    end
    if (cmd_i.out_det) begin
      out_d = '0;
      out_d.out_source_id = item_q.src_id;
      out_d.out_object_id = item_q.obj_id;
      out_d.out_quality = item_q.quality;
      out_d.is_last = 1'b1;
      if (!ok) begin
        out_d.kind = KindSkipped;
        out_d.resend = had_sent;
        out_d.sent_cnt = had_sent ? sent_n_q[hit_idx_q] : 8'd0;
      end else if (!hit_q && !free_found_q) begin
        out_d.kind = KindFull;
      end else begin
        out_d.kind = KindQueued;
        out_d.resend = had_sent;
        out_d.sent_cnt = had_sent ? sent_n_q[hit_idx_q] : 8'd0;
      end
    end
    if (cmd_i.out_sent) begin
      out_d = '0;
      out_d.kind = KindSent;
      out_d.out_source_id = key_src_q[idx];
      out_d.out_object_id = key_obj_q[idx];
      out_d.out_quality = pend_q_q[idx];
      out_d.resend = pend_rs_q[idx];
      out_d.sent_cnt = new_cnt;
    end
    if (cmd_i.out_done) begin
      out_d = '0;
      out_d.kind = KindTickDone;
      out_d.rm_sent = 6'(rms_q);
      out_d.rm_pend = 6'(rmp_q);
      out_d.sent_in_tick = 6'(sit_q);
      out_d.is_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.send_apply) begin
      sent_n_q[idx] <= new_cnt;
      sent_qa_q[idx] <= pend_q_q[idx];
      sent_ls_q[idx] <= item_q.now_ms;
    end
    if (cmd_i.det_apply) begin
      if (had_sent) begin
        sent_ls_q[hit_idx_q] <= item_q.now_ms;
      end
      if (ok && hit_q) begin
        pend_q_q[hit_idx_q] <= item_q.quality;
        pend_t_q[hit_idx_q] <= item_q.now_ms;
        pend_rs_q[hit_idx_q] <= had_sent;
      end else if (ok && free_found_q) begin
        key_src_q[free_idx_q] <= item_q.src_id;
        key_obj_q[free_idx_q] <= item_q.obj_id;
        pend_q_q[free_idx_q] <= item_q.quality;
        pend_t_q[free_idx_q] <= item_q.now_ms;
        pend_rs_q[free_idx_q] <= 1'b0;
      end
    end
    if (out_set) begin
      out_q <= out_d;
    end
  end
endmodule

[sv/quality_gated_detection_table_top.sv]
// Detection item: the key search walks one entry per cycle over all entries.
// Tick item: an optional sweep pass over all entries when cleanup is due,
// then a send pass over all entries that sends each entry past its send delay.
// One item in flight at a time; the result register lets the next item start.
// Reset clears the valid bits, the cleanup time and loads configuration defaults.
module quality_gated_detection_table_top (
  input logic clk_i,
  input logic rst_ni,
  qgdt_if.sink   in_if,
  qgdt_if.source out_if,
  qgdt_if.sink   cfg_if
);
  import qgdt_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_if.ready = 1'b1;

  qgdt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_if.valid),
    .in_ready_o(in_if.ready),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  qgdt_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_if.data),
    .cfg_we_i   (cfg_if.valid),
    .cfg_data_i (cfg_if.data),
    .cmd_i      (cmd),
    .st_o       (st),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .out_data_o (out_if.data)
  );
endmodule
